// File: design/jpva_pkg.sv
package jpva_pkg;

  // default value width and fixed-point format
  localparam int VALUE_WIDTH_DEF = 32;
  localparam int FRAC_BITS = 16;

  // configuration port
  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;

  // register indexes
  localparam logic [2:0] REG_PROP_GAIN   = 3'd0;
  localparam logic [2:0] REG_INT_GAIN    = 3'd1;
  localparam logic [2:0] REG_MAX_VEL     = 3'd2;
  localparam logic [2:0] REG_UPPER_LIMIT = 3'd3;
  localparam logic [2:0] REG_LOWER_LIMIT = 3'd4;

  // register reset values
  localparam logic [30:0]        PROP_GAIN_RST   = 31'd65536;
  localparam logic [30:0]        INT_GAIN_RST    = 31'd65536;
  localparam logic [30:0]        MAX_VEL_RST     = 31'd65536;
  localparam logic signed [31:0] UPPER_LIMIT_RST = 32'sd376183;
  localparam logic signed [31:0] LOWER_LIMIT_RST = 32'sd7216;

  // input item
  typedef struct packed {
    logic signed [31:0] joint_angle;
    logic signed [31:0] feedback_torque;
    logic signed [31:0] setpoint_torque;
    logic        [30:0] period;
  } in_item_t;

  // result item
  typedef struct packed {
    logic signed [31:0] vel_cmd;
    logic               saturated;
    logic               at_limit;
  } out_item_t;

endpackage

// File: design/jpva_mul.sv
module jpva_mul #(
  parameter int VALUE_WIDTH = jpva_pkg::VALUE_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [VALUE_WIDTH-1:0]     a,
  input  logic [VALUE_WIDTH-1:0]     b,
  output logic                       done,
  output logic [2*VALUE_WIDTH-1:0]   prod
);

  localparam int W  = VALUE_WIDTH;
  localparam int PW = 2 * W;
  localparam int CW = $clog2(W);

  logic [W-1:0]  mcand_r, mcand_nxt;
  logic [PW-1:0] prod_r, prod_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [W:0]    sum;

  // one multiplier bit per cycle: add on the low bit, shift right
  always_comb begin
    sum       = {1'b0, prod_r[PW-1:W]} + (prod_r[0] ? {1'b0, mcand_r} : '0);
    mcand_nxt = mcand_r;
    prod_nxt  = prod_r;
    cnt_nxt   = cnt_r;
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    if (start) begin
      mcand_nxt = a;
      prod_nxt  = {{W{1'b0}}, b};
      cnt_nxt   = '0;
      busy_nxt  = 1'b1;
    end else if (busy_r) begin
      prod_nxt = {sum, prod_r[W-1:1]};
      cnt_nxt  = cnt_r + 1'b1;
      if (cnt_r == CW'(W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    mcand_r <= mcand_nxt;
    prod_r  <= prod_nxt;
    cnt_r   <= cnt_nxt;
  end

  assign done = done_r;
  assign prod = prod_r;

endmodule

// File: design/jpva_div.sv
module jpva_div #(
  parameter int VALUE_WIDTH = jpva_pkg::VALUE_WIDTH_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     start,
  input  logic [VALUE_WIDTH+jpva_pkg::FRAC_BITS-1:0] dividend,
  input  logic [VALUE_WIDTH-1:0]                   divisor,
  output logic                                     done,
  output logic [VALUE_WIDTH+jpva_pkg::FRAC_BITS-1:0] quotient
);

  import jpva_pkg::*;

  localparam int W  = VALUE_WIDTH;
  localparam int DW = W + FRAC_BITS;
  localparam int CW = $clog2(DW);

  logic [DW-1:0] quo_r, quo_nxt;
  logic [W-1:0]  rem_r, rem_nxt;
  logic [W-1:0]  dsr_r, dsr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [W:0]    trial;
  logic [W:0]    diff;
  logic          ge;

  // restoring division, one quotient bit per cycle
  always_comb begin
    trial    = {rem_r, quo_r[DW-1]};
    ge       = (trial >= {1'b0, dsr_r});
    diff     = trial - {1'b0, dsr_r};
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      quo_nxt = {quo_r[DW-2:0], ge};
      rem_nxt = ge ? diff[W-1:0] : trial[W-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(DW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
    cnt_r <= cnt_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// File: design/joint_pi_velocity_antiwindup.sv
// an item is processed by the bit-serial multipliers and, when the command
// clamps and the integral gain is nonzero, by the divider (back-calculation)
// one item at a time: a new item is accepted only in the idle state
// reset: synchronous active-low rst_n clears the integral, the sequencer and
// the result valid, and loads the register defaults
module joint_pi_velocity_antiwindup #(
  parameter int VALUE_WIDTH = jpva_pkg::VALUE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  jpva_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output jpva_pkg::out_item_t           out_data,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [jpva_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [jpva_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [jpva_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                          cfg_pready
);

  import jpva_pkg::*;

  localparam int W  = VALUE_WIDTH;
  localparam int PW = 2 * W;
  localparam int DW = W + FRAC_BITS;
  localparam int XW = ((W > 32) ? W : 32) + 2;

  localparam logic signed [XW-1:0] VMAX_X  = (XW'(1) << (W - 1)) - XW'(1);
  localparam logic signed [XW-1:0] VMIN_X  = -VMAX_X - XW'(1);
  localparam logic signed [XW-1:0] OMAX_X  = XW'(32'h7FFF_FFFF);
  localparam logic signed [XW-1:0] OMIN_X  = -OMAX_X - XW'(1);
  localparam logic [PW-1:0]        CAP_POS = (PW'(1) << (W - 1)) - PW'(1);
  localparam logic [PW-1:0]        CAP_NEG = PW'(1) << (W - 1);

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL1  = 3'd1;
  localparam logic [2:0] S_INTEG = 3'd2;
  localparam logic [2:0] S_MUL2  = 3'd3;
  localparam logic [2:0] S_CHECK = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  // saturate a wide signed value to the value width
  function automatic logic signed [W-1:0] sat_x(input logic signed [XW-1:0] v);
    if (v > VMAX_X) begin
      sat_x = VMAX_X[W-1:0];
    end else if (v < VMIN_X) begin
      sat_x = VMIN_X[W-1:0];
    end else begin
      sat_x = v[W-1:0];
    end
  endfunction

  // magnitude of a signed value, full negative included
  function automatic logic [W-1:0] mag(input logic signed [W-1:0] v);
    mag = v[W-1] ? (~v + 1'b1) : v;
  endfunction

  // cap a magnitude to the signed range and apply the sign
  function automatic logic signed [W-1:0] qcap(input logic [PW-1:0] m, input logic neg);
    logic [PW-1:0] cap;
    logic [W-1:0]  r;
    cap  = neg ? CAP_NEG : CAP_POS;
    r    = (m > cap) ? cap[W-1:0] : m[W-1:0];
    qcap = neg ? (~r + 1'b1) : r;
  endfunction

  // configuration registers
  logic [30:0]        prop_gain_r;
  logic [30:0]        int_gain_r;
  logic [30:0]        max_vel_r;
  logic signed [31:0] upper_limit_r;
  logic signed [31:0] lower_limit_r;
  logic               cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_gain_r   <= PROP_GAIN_RST;
      int_gain_r    <= INT_GAIN_RST;
      max_vel_r     <= MAX_VEL_RST;
      upper_limit_r <= UPPER_LIMIT_RST;
      lower_limit_r <= LOWER_LIMIT_RST;
    end else if (cfg_wr) begin
      case (cfg_paddr[4:2])
        REG_PROP_GAIN:   prop_gain_r   <= cfg_pwdata[30:0];
        REG_INT_GAIN:    int_gain_r    <= cfg_pwdata[30:0];
        REG_MAX_VEL:     max_vel_r     <= cfg_pwdata[30:0];
        REG_UPPER_LIMIT: upper_limit_r <= cfg_pwdata;
        REG_LOWER_LIMIT: lower_limit_r <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (cfg_paddr[4:2])
      REG_PROP_GAIN:   cfg_prdata = {1'b0, prop_gain_r};
      REG_INT_GAIN:    cfg_prdata = {1'b0, int_gain_r};
      REG_MAX_VEL:     cfg_prdata = {1'b0, max_vel_r};
      REG_UPPER_LIMIT: cfg_prdata = upper_limit_r;
      REG_LOWER_LIMIT: cfg_prdata = lower_limit_r;
      default:         cfg_prdata = '0;
    endcase
  end

  // gains and limit at the value width
  logic signed [W-1:0] kp_s, ki_s, vmax_s;
  logic                ki_zero;

  assign kp_s    = sat_x(XW'(prop_gain_r));
  assign ki_s    = sat_x(XW'(int_gain_r));
  assign vmax_s  = sat_x(XW'(max_vel_r));
  assign ki_zero = (ki_s == '0);

  // input item front end
  logic signed [31:0]  fb_in, sp_in, angle_in;
  logic signed [W-1:0] fb_w, sp_w, err_in, per_w;
  logic                lim_in;
  logic                accept;

  assign fb_in    = in_data.feedback_torque;
  assign sp_in    = in_data.setpoint_torque;
  assign angle_in = in_data.joint_angle;
  assign fb_w     = sat_x(XW'(fb_in));
  assign sp_w     = sat_x(XW'(sp_in));
  assign per_w    = sat_x(XW'(in_data.period));
  assign err_in   = sat_x(XW'(fb_w) + XW'(sp_w));
  assign lim_in   = (angle_in >= upper_limit_r) || (angle_in <= lower_limit_r);

  // sequencer and datapath registers
  logic [2:0]          state_r, state_nxt;
  logic signed [W-1:0] integral_r, integral_nxt;
  logic signed [W-1:0] p_r, p_nxt;
  logic signed [W-1:0] cmd_r, cmd_nxt;
  logic                err_neg_r, err_neg_nxt;
  logic                lim_r, lim_nxt;
  logic                sat_r, sat_nxt;
  logic                nneg_r, nneg_nxt;
  out_item_t           out_r, out_nxt;
  logic                out_valid_r, out_valid_nxt;

  // serial units
  logic          mul_a_start, mul_b_start, mul_a_done, mul_b_done;
  logic [W-1:0]  mul_a_x, mul_a_y;
  logic [PW-1:0] prod_a, prod_b;
  logic          div_start, div_done;
  logic [DW-1:0] div_dividend, div_quot;
  logic [PW-1:0] div_quot_ext;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  // integral update from err*period
  logic signed [W-1:0] q1, p_val, integ_upd;

  assign q1        = qcap(prod_a >> FRAC_BITS, err_neg_r);
  assign p_val     = qcap(prod_b >> FRAC_BITS, err_neg_r);
  assign integ_upd = lim_r ? '0 : sat_x(XW'(integral_r) + XW'(q1));

  // command, clamp and back-calculation numerator
  logic signed [W-1:0] q3, cmd_val, target;
  logic [W-1:0]        cmd_mag;
  logic                clamp;
  logic signed [W:0]   n_val;
  logic [W:0]          n_abs;

  assign q3      = qcap(prod_a >> FRAC_BITS, integral_r[W-1]);
  assign cmd_val = sat_x(XW'(p_r) + XW'(q3));
  assign cmd_mag = mag(cmd_val);
  assign clamp   = (cmd_mag >= $unsigned(vmax_s));
  assign target  = cmd_val[W-1] ? -vmax_s : ((cmd_val != '0) ? vmax_s : '0);
  assign n_val   = (W+1)'(target) - (W+1)'(p_r);
  assign n_abs   = n_val[W] ? (~n_val + 1'b1) : n_val;

  // multiplier a: err*period first, then int_gain*integral
  assign mul_a_start  = accept || (state_r == S_INTEG);
  assign mul_a_x      = (state_r == S_IDLE) ? mag(err_in) : $unsigned(ki_s);
  assign mul_a_y      = (state_r == S_IDLE) ? $unsigned(per_w) : mag(integ_upd);
  assign mul_b_start  = accept;
  assign div_start    = (state_r == S_CHECK) && clamp && !ki_zero;
  assign div_dividend = {n_abs[W-1:0], {FRAC_BITS{1'b0}}};
  assign div_quot_ext = PW'(div_quot);

  jpva_mul #(.VALUE_WIDTH(VALUE_WIDTH)) u_mul_a (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_a_start),
    .a     (mul_a_x),
    .b     (mul_a_y),
    .done  (mul_a_done),
    .prod  (prod_a)
  );

  jpva_mul #(.VALUE_WIDTH(VALUE_WIDTH)) u_mul_b (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_b_start),
    .a     ($unsigned(kp_s)),
    .b     (mag(err_in)),
    .done  (mul_b_done),
    .prod  (prod_b)
  );

  jpva_div #(.VALUE_WIDTH(VALUE_WIDTH)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  ($unsigned(ki_s)),
    .done     (div_done),
    .quotient (div_quot)
  );

  // command narrowed to the 32-bit result field
  logic signed [XW-1:0] cmd_x;
  logic signed [31:0]   vel32;

  assign cmd_x = XW'(cmd_r);
  assign vel32 = (cmd_x > OMAX_X) ? OMAX_X[31:0] :
                 (cmd_x < OMIN_X) ? OMIN_X[31:0] : cmd_x[31:0];

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    integral_nxt  = integral_r;
    p_nxt         = p_r;
    cmd_nxt       = cmd_r;
    err_neg_nxt   = err_neg_r;
    lim_nxt       = lim_r;
    sat_nxt       = sat_r;
    nneg_nxt      = nneg_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          err_neg_nxt = err_in[W-1];
          lim_nxt     = lim_in;
          state_nxt   = S_MUL1;
        end
      end
      S_MUL1: begin
        if (mul_a_done && mul_b_done) begin
          state_nxt = S_INTEG;
        end
      end
      S_INTEG: begin
        integral_nxt = integ_upd;
        p_nxt        = p_val;
        state_nxt    = S_MUL2;
      end
      S_MUL2: begin
        if (mul_a_done) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd_nxt  = clamp ? target : cmd_val;
        sat_nxt  = clamp;
        nneg_nxt = n_val[W];
        if (clamp && ki_zero) begin
          integral_nxt = '0;
        end
        state_nxt = (clamp && !ki_zero) ? S_DIV : S_OUT;
      end
      S_DIV: begin
        if (div_done) begin
          integral_nxt = qcap(div_quot_ext, nneg_r);
          state_nxt    = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_nxt.vel_cmd   = vel32;
          out_nxt.saturated = sat_r;
          out_nxt.at_limit  = lim_r;
          out_valid_nxt     = 1'b1;
          state_nxt         = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      integral_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      integral_r  <= integral_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    p_r       <= p_nxt;
    cmd_r     <= cmd_nxt;
    err_neg_r <= err_neg_nxt;
    lim_r     <= lim_nxt;
    sat_r     <= sat_nxt;
    nneg_r    <= nneg_nxt;
    out_r     <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef NO_ASSERTIONS
  // integral cleared before the command is formed when at a joint limit
  a_limit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL2) && lim_r |-> (integral_r == '0))
    else $error("integral not cleared at joint limit");

  // divider runs only for a clamped item
  a_div_on_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> sat_r)
    else $error("back-calculation without clamp");

  // a clamped result carries the velocity limit
  a_clamp_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.saturated |->
      (out_r.vel_cmd == 32'(vmax_s)) ||
      (out_r.vel_cmd == -32'(vmax_s)))
    else $error("clamped command differs from limit");

  // a result appears only from the output step
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_OUT))
    else $error("result valid raised outside output step");
`endif

endmodule
